FILE: design/irpd_pkg.sv
package irpd_pkg;

    // Register file layout of the configuration port
    localparam int unsigned CFG_COUNT    = 6;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned TICK_W       = 8;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned BITCNT_W     = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREAMBLE_MIN = 3'd0,
        CFG_PREAMBLE_MAX = 3'd1,
        CFG_ZERO_MIN     = 3'd2,
        CFG_ZERO_MAX     = 3'd3,
        CFG_ONE_MIN      = 3'd4,
        CFG_ONE_MAX      = 3'd5
    } cfg_idx_t;

    // Reset values of the timing windows
    localparam logic [TICK_W-1:0] PREAMBLE_MIN_RST = 8'd195;
    localparam logic [TICK_W-1:0] PREAMBLE_MAX_RST = 8'd239;
    localparam logic [TICK_W-1:0] ZERO_MIN_RST     = 8'd16;
    localparam logic [TICK_W-1:0] ZERO_MAX_RST     = 8'd20;
    localparam logic [TICK_W-1:0] ONE_MIN_RST      = 8'd32;
    localparam logic [TICK_W-1:0] ONE_MAX_RST      = 8'd39;

    // Bits in one frame
    localparam logic [BITCNT_W-1:0] FRAME_BITS = 6'd32;

    // Item mode codes
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_ACK  = 1'b1;

    // One captured input item
    typedef struct packed {
        logic              mode;
        logic [TICK_W-1:0] ticks;
        logic              ovf;
    } item_t;

    // Inclusive window match
    function automatic logic in_window(
        input logic [TICK_W-1:0] t,
        input logic [TICK_W-1:0] lo,
        input logic [TICK_W-1:0] hi
    );
        in_window = (t >= lo) && (t <= hi);
    endfunction

    // Address and command bytes must each match their inverted copy
    function automatic logic frame_ok(input logic [WORD_W-1:0] w);
        frame_ok = (w[31:24] == ~w[23:16]) && (w[15:8] == ~w[7:0]);
    endfunction

endpackage

FILE: design/ir_pulse_distance_decoder.sv
// Pulse-distance IR frame decoder (NEC-style, 32-bit frames). Each input
// transfer reports one falling edge (tick count since the previous edge and
// a timer-overflow flag, an overflowed interval counting as zero) or, with
// mode set, an acknowledge that releases a finished frame. Every item gives
// exactly one result: the receiver state after the item, a frame_done pulse
// on the edge that completed a frame whose address and command bytes match
// their inverted copies, the 32-bit shift word (first bit in bit 31) and its
// address and command bytes. It takes one item per clock while in_stall is
// low; a result passes the input register and then the result register, and
// the state update of one item is complete before the next leaves the input
// register. The six 8-bit window registers (preamble, zero, one; min and
// max, inclusive) are written through the configuration port; the user must
// write them only while no item is in flight; the block does not enforce
// this. cfg_ready is always high; writes to indexes beyond five are dropped.
module ir_pulse_distance_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    // input item channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [irpd_pkg::TICK_W-1:0]    interval_ticks,
    input  logic                           timer_overflow,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     receiver_state,
    output logic                           frame_done,
    output logic [irpd_pkg::WORD_W-1:0]    frame_word,
    output logic [irpd_pkg::BYTE_W-1:0]    address,
    output logic [irpd_pkg::BYTE_W-1:0]    command,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irpd_pkg::TICK_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // Window registers
    logic [irpd_pkg::TICK_W-1:0] pre_min_reg, pre_max_reg;
    logic [irpd_pkg::TICK_W-1:0] zero_min_reg, zero_max_reg;
    logic [irpd_pkg::TICK_W-1:0] one_min_reg, one_max_reg;

    // Input stage
    logic                s1_valid_reg;
    irpd_pkg::item_t     s1_item_reg;

    // Receiver state
    phase_t                         phase_reg, phase_next;
    logic [irpd_pkg::BITCNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [irpd_pkg::WORD_W-1:0]    shift_reg, shift_next;
    logic                           done_next;

    // Result stage
    logic                           out_valid_reg;
    phase_t                         out_phase_reg;
    logic                           out_done_reg;
    logic [irpd_pkg::WORD_W-1:0]    out_word_reg;

    logic                           in_xfer;
    logic                           proc;
    logic [irpd_pkg::TICK_W-1:0]    t_eff;
    logic                           is_one, is_zero;

    // Advance the input stage whenever the result register is free or draining
    assign proc     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    // Classify the interval
    assign t_eff   = s1_item_reg.ovf ? '0 : s1_item_reg.ticks;
    assign is_one  = irpd_pkg::in_window(t_eff, one_min_reg, one_max_reg);
    assign is_zero = irpd_pkg::in_window(t_eff, zero_min_reg, zero_max_reg);

    // Next receiver state for the item in the input stage
    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        done_next      = 1'b0;
        if (s1_item_reg.mode == irpd_pkg::MODE_ACK)
        begin
            if (phase_reg == PH_DONE)
            begin
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (irpd_pkg::in_window(t_eff, pre_min_reg, pre_max_reg))
                    begin
                        bit_count_next = '0;
                        phase_next     = PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    shift_next = {shift_reg[irpd_pkg::WORD_W-2:0], is_one};
                    if (is_one || is_zero)
                    begin
                        bit_count_next = bit_count_reg + 1'b1;
                        if (bit_count_next == irpd_pkg::FRAME_BITS)
                        begin
                            if (irpd_pkg::frame_ok(shift_next))
                            begin
                                phase_next = PH_DONE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Hold configuration, input stage, receiver state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_min_reg   <= irpd_pkg::PREAMBLE_MIN_RST;
            pre_max_reg   <= irpd_pkg::PREAMBLE_MAX_RST;
            zero_min_reg  <= irpd_pkg::ZERO_MIN_RST;
            zero_max_reg  <= irpd_pkg::ZERO_MAX_RST;
            one_min_reg   <= irpd_pkg::ONE_MIN_RST;
            one_max_reg   <= irpd_pkg::ONE_MAX_RST;
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_phase_reg <= PH_IDLE;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            // write a window register; drop unknown indexes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    irpd_pkg::CFG_PREAMBLE_MIN: pre_min_reg  <= cfg_data;
                    irpd_pkg::CFG_PREAMBLE_MAX: pre_max_reg  <= cfg_data;
                    irpd_pkg::CFG_ZERO_MIN:     zero_min_reg <= cfg_data;
                    irpd_pkg::CFG_ZERO_MAX:     zero_max_reg <= cfg_data;
                    irpd_pkg::CFG_ONE_MIN:      one_min_reg  <= cfg_data;
                    irpd_pkg::CFG_ONE_MAX:      one_max_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // capture an input transfer, or empty the stage once processed
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
                s1_item_reg  <= '{mode: mode, ticks: interval_ticks, ovf: timer_overflow};
            end
            else if (proc)
            begin
                s1_valid_reg <= 1'b0;
            end

            // commit the item and load the result register
            if (proc)
            begin
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                shift_reg     <= shift_next;
                out_valid_reg <= 1'b1;
                out_phase_reg <= phase_next;
                out_done_reg  <= done_next;
                out_word_reg  <= shift_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign receiver_state = out_phase_reg;
    assign frame_done     = out_done_reg;
    assign frame_word     = out_word_reg;
    assign address        = out_word_reg[31:24];
    assign command        = out_word_reg[15:8];

    // A completed frame is always reported in the done state
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_phase_reg == PH_DONE)
        else $error("frame_done without done state");

    // The bit counter never passes a frame length while receiving
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RECV |-> bit_count_reg < irpd_pkg::FRAME_BITS)
        else $error("bit counter out of range while receiving");

    // Only an acknowledge leaves the done state
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE && !(proc && s1_item_reg.mode == irpd_pkg::MODE_ACK)
        |=> phase_reg == PH_DONE)
        else $error("done state left without acknowledge");

    // A result that was taken and not replaced disappears
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !proc |=> !out_valid_reg)
        else $error("result repeated");

    // Back-pressure only with a full input stage behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled without cause");

endmodule

FILE: sim/ir_pulse_distance_decoder_tb.sv
module ir_pulse_distance_decoder_tb;

    // Field widths taken from the package
    localparam int unsigned TICK_W    = irpd_pkg::TICK_W;
    localparam int unsigned WORD_W    = irpd_pkg::WORD_W;
    localparam int unsigned BYTE_W    = irpd_pkg::BYTE_W;
    localparam int unsigned BITCNT_W  = irpd_pkg::BITCNT_W;
    localparam int unsigned CFG_IDX_W = irpd_pkg::CFG_IDX_W;
    localparam int unsigned CFG_COUNT = irpd_pkg::CFG_COUNT;

    // Receiver phases as the decoder reports them
    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_RECV = 2'd1,
        RX_DONE = 2'd2
    } rx_phase_t;

    // One decoder result, field for field
    typedef struct packed {
        logic [1:0]        state;
        logic              done;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] cmd;
    } ir_result_t;

    // Kinds of generated frames
    localparam int FRAME_CLEAN     = 0;
    localparam int FRAME_BAD_CHECK = 1;
    localparam int FRAME_BROKEN    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(CFG_COUNT);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = CFG_IDX_W'(CFG_COUNT + 1);

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              mode = irpd_pkg::MODE_EDGE;
    logic [TICK_W-1:0] interval_ticks = '0;
    logic              timer_overflow = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        receiver_state;
    logic              frame_done;
    logic [WORD_W-1:0] frame_word;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] command;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0] cfg_data = '0;

    // Predictor state and its copy of the window registers
    logic [TICK_W-1:0]   pred_win [CFG_COUNT];
    rx_phase_t           pred_phase = RX_IDLE;
    logic [BITCNT_W-1:0] pred_nbits = '0;
    logic [WORD_W-1:0]   pred_word = '0;

    irpd_pkg::item_t pending_items[$];
    ir_result_t      result_due_q[$];
    int         pushed_count = 0;
    int         result_count = 0;
    int         mismatch_count = 0;
    int         in_gap = 0;
    int         in_calm = 0;
    int         out_hold = 0;
    int         out_calm = 0;

    ir_pulse_distance_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .interval_ticks (interval_ticks),
        .timer_overflow (timer_overflow),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .receiver_state (receiver_state),
        .frame_done     (frame_done),
        .frame_word     (frame_word),
        .address        (address),
        .command        (command),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        pred_win[irpd_pkg::CFG_PREAMBLE_MIN] = irpd_pkg::PREAMBLE_MIN_RST;
        pred_win[irpd_pkg::CFG_PREAMBLE_MAX] = irpd_pkg::PREAMBLE_MAX_RST;
        pred_win[irpd_pkg::CFG_ZERO_MIN]     = irpd_pkg::ZERO_MIN_RST;
        pred_win[irpd_pkg::CFG_ZERO_MAX]     = irpd_pkg::ZERO_MAX_RST;
        pred_win[irpd_pkg::CFG_ONE_MIN]      = irpd_pkg::ONE_MIN_RST;
        pred_win[irpd_pkg::CFG_ONE_MAX]      = irpd_pkg::ONE_MAX_RST;
    end

    // Advance the decoder state by one item and return what it reports
    function automatic ir_result_t decode_step(
        input logic              md,
        input logic [TICK_W-1:0] ticks,
        input logic              ovf
    );
        ir_result_t        r;
        logic [TICK_W-1:0] t;
        logic              got_done;
        logic              is_pre;
        logic              is_one;
        logic              is_zero;
        got_done = 1'b0;
        t = ovf ? '0 : ticks;
        is_pre  = (t >= pred_win[irpd_pkg::CFG_PREAMBLE_MIN]) &&
                  (t <= pred_win[irpd_pkg::CFG_PREAMBLE_MAX]);
        is_one  = (t >= pred_win[irpd_pkg::CFG_ONE_MIN]) &&
                  (t <= pred_win[irpd_pkg::CFG_ONE_MAX]);
        is_zero = (t >= pred_win[irpd_pkg::CFG_ZERO_MIN]) &&
                  (t <= pred_win[irpd_pkg::CFG_ZERO_MAX]);
        if (md == irpd_pkg::MODE_ACK)
        begin
            if (pred_phase == RX_DONE)
                pred_phase = RX_IDLE;
        end
        else
        begin
            case (pred_phase)
                RX_IDLE:
                begin
                    if (is_pre)
                    begin
                        pred_nbits = '0;
                        pred_phase = RX_RECV;
                    end
                end
                RX_RECV:
                begin
                    // shift first, then decide whether the interval was a bit at all
                    pred_word = {pred_word[WORD_W-2:0], is_one};
                    if (is_one || is_zero)
                        pred_nbits = pred_nbits + 1'b1;
                    else
                        pred_phase = RX_IDLE;
                    if (pred_phase == RX_RECV && pred_nbits == irpd_pkg::FRAME_BITS)
                    begin
                        if ((pred_word[31:24] ^ pred_word[23:16]) == 8'hff &&
                            (pred_word[15:8] ^ pred_word[7:0]) == 8'hff)
                        begin
                            pred_phase = RX_DONE;
                            got_done = 1'b1;
                        end
                        else
                            pred_phase = RX_IDLE;
                    end
                end
                RX_DONE: ;
                default: pred_phase = RX_IDLE;
            endcase
        end
        r.state = pred_phase;
        r.done  = got_done;
        r.word  = pred_word;
        r.addr  = pred_word[31:24];
        r.cmd   = pred_word[15:8];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("error: result %0d: %s", result_count, what);
        mismatch_count++;
    endtask

    // Draw the wait before the next transfer, with occasional runs of none
    task automatic draw_hold(inout int calm_run, output int hold);
        if (calm_run > 0)
        begin
            calm_run--;
            hold = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            calm_run = $urandom_range(8, 40);
            hold = 0;
        end
        else
            hold = $urandom_range(0, 6);
    endtask

    task automatic check_result();
        ir_result_t want;
        if (result_due_q.size() == 0)
        begin
            report_mismatch("result with no item outstanding");
            return;
        end
        want = result_due_q.pop_front();
        if (receiver_state != want.state)
            report_mismatch($sformatf("receiver_state %0d, want %0d",
                                      receiver_state, want.state));
        if (frame_done != want.done)
            report_mismatch($sformatf("frame_done %0d, want %0d", frame_done, want.done));
        if (frame_word != want.word)
            report_mismatch($sformatf("frame_word %h, want %h", frame_word, want.word));
        if (address != want.addr)
            report_mismatch($sformatf("address %h, want %h", address, want.addr));
        if (command != want.cmd)
            report_mismatch($sformatf("command %h, want %h", command, want.cmd));
    endtask

    // Input driver: predict on each transfer, then present the next item
    always @(posedge clk)
    begin
        irpd_pkg::item_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                result_due_q.push_back(decode_step(mode, interval_ticks, timer_overflow));
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    mode           <= nxt.mode;
                    interval_ticks <= nxt.ticks;
                    timer_overflow <= nxt.ovf;
                    in_valid       <= 1'b1;
                    draw_hold(in_calm, in_gap);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each transfer, then stall for a drawn time
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
                result_count++;
                draw_hold(out_calm, out_hold);
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_item(input logic md, input logic [TICK_W-1:0] ticks,
                             input logic ovf);
        irpd_pkg::item_t it;
        it.mode  = md;
        it.ticks = ticks;
        it.ovf   = ovf;
        pending_items.push_back(it);
        pushed_count++;
    endtask

    // Pick an interval inside a window; an empty window gets a random one
    task automatic pick_tick(input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi,
                             output logic [TICK_W-1:0] ticks, output logic ovf);
        ovf = 1'b0;
        if (lo > hi)
            ticks = TICK_W'($urandom);
        else
        begin
            ticks = TICK_W'($urandom_range(hi, lo));
            // a zero interval may also come as a timer overflow
            if (ticks == '0 && $urandom_range(0, 1) == 1)
            begin
                ticks = TICK_W'($urandom);
                ovf = 1'b1;
            end
        end
    endtask

    task automatic push_frame(input int flavor);
        logic [TICK_W-1:0] t;
        logic              ov;
        logic [BYTE_W-1:0] adr;
        logic [BYTE_W-1:0] cmd_b;
        logic [WORD_W-1:0] w;
        int                cut;
        logic              live;
        adr   = BYTE_W'($urandom);
        cmd_b = BYTE_W'($urandom);
        w = {adr, ~adr, cmd_b, ~cmd_b};
        if (flavor == FRAME_BAD_CHECK)
            w = w ^ (32'd1 << $urandom_range(0, 31));
        cut = (flavor == FRAME_BROKEN) ? int'($urandom_range(0, 31)) : int'(WORD_W);
        live = 1'b1;
        pick_tick(pred_win[irpd_pkg::CFG_PREAMBLE_MIN], pred_win[irpd_pkg::CFG_PREAMBLE_MAX],
                  t, ov);
        push_item(irpd_pkg::MODE_EDGE, t, ov);
        for (int b = int'(WORD_W) - 1; b >= 0; b--)
        begin
            if (live)
            begin
                if (int'(WORD_W) - 1 - b == cut)
                begin
                    // drop a noise interval into the frame and stop
                    push_item(irpd_pkg::MODE_EDGE, TICK_W'($urandom),
                              $urandom_range(0, 3) == 0);
                    live = 1'b0;
                end
                else
                begin
                    if (w[b])
                        pick_tick(pred_win[irpd_pkg::CFG_ONE_MIN],
                                  pred_win[irpd_pkg::CFG_ONE_MAX], t, ov);
                    else
                        pick_tick(pred_win[irpd_pkg::CFG_ZERO_MIN],
                                  pred_win[irpd_pkg::CFG_ZERO_MAX], t, ov);
                    push_item(irpd_pkg::MODE_EDGE, t, ov);
                end
            end
        end
        // edges after a completed frame are ignored while done
        if ($urandom_range(0, 3) == 0)
            push_item(irpd_pkg::MODE_EDGE, TICK_W'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) != 0)
            push_item(irpd_pkg::MODE_ACK, TICK_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_traffic(input int budget);
        int goal;
        int pick;
        goal = pushed_count + budget;
        while (pushed_count < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                push_frame(FRAME_CLEAN);
            else if (pick == 7)
                push_frame(FRAME_BAD_CHECK);
            else if (pick == 8)
                push_frame(FRAME_BROKEN);
            else
                repeat ($urandom_range(1, 5))
                    push_item($urandom_range(0, 3) == 0 ? irpd_pkg::MODE_ACK
                                                        : irpd_pkg::MODE_EDGE,
                              TICK_W'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    // Wait until every item has been sent and every result has come back
    task automatic settle();
        while (pending_items.size() != 0 || in_valid || result_due_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < CFG_COUNT)
            pred_win[idx] = val;
    endtask

    task automatic set_windows(input logic [TICK_W-1:0] pmin, input logic [TICK_W-1:0] pmax,
                               input logic [TICK_W-1:0] zmin, input logic [TICK_W-1:0] zmax,
                               input logic [TICK_W-1:0] omin, input logic [TICK_W-1:0] omax);
        write_reg(irpd_pkg::CFG_PREAMBLE_MIN, pmin);
        write_reg(irpd_pkg::CFG_PREAMBLE_MAX, pmax);
        write_reg(irpd_pkg::CFG_ZERO_MIN, zmin);
        write_reg(irpd_pkg::CFG_ZERO_MAX, zmax);
        write_reg(irpd_pkg::CFG_ONE_MIN, omin);
        write_reg(irpd_pkg::CFG_ONE_MAX, omax);
    endtask

    task automatic set_random_windows();
        logic [TICK_W-1:0] lo [3];
        logic [TICK_W-1:0] hi [3];
        for (int k = 0; k < 3; k++)
        begin
            lo[k] = TICK_W'($urandom_range(0, 250));
            hi[k] = TICK_W'($urandom_range(255, lo[k]));
        end
        set_windows(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
    endtask

    // Run limit
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset windows: field extremes, window edges and the idle/receive cases
        push_item(irpd_pkg::MODE_ACK, 8'd0, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd0, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd255, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd200, 1'b1);
        push_item(irpd_pkg::MODE_EDGE, 8'd194, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd240, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd195, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd16, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd20, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd32, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd39, 1'b0);
        push_item(irpd_pkg::MODE_ACK, 8'd255, 1'b1);
        push_item(irpd_pkg::MODE_EDGE, 8'd15, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd239, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd40, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd217, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd36, 1'b1);
        push_item(irpd_pkg::MODE_EDGE, 8'd31, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd221, 1'b0);
        push_item(irpd_pkg::MODE_EDGE, 8'd21, 1'b0);
        push_frame(FRAME_CLEAN);
        push_frame(FRAME_BAD_CHECK);
        run_traffic(250);
        settle();

        // Random windows
        set_random_windows();
        run_traffic(300);
        settle();

        // Everything is a preamble and a zero; the one window is empty
        set_windows(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0);
        run_traffic(100);
        settle();

        // Both bit windows match zero; only 255 starts a frame; spare indexes dropped
        set_windows(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
        write_reg(CFG_IDX_SPARE_LO, 8'hff);
        write_reg(CFG_IDX_SPARE_HI, 8'h00);
        run_traffic(100);
        settle();

        set_random_windows();
        run_traffic(300);
        settle();

        // Back to the power-on timing
        set_windows(irpd_pkg::PREAMBLE_MIN_RST, irpd_pkg::PREAMBLE_MAX_RST,
                    irpd_pkg::ZERO_MIN_RST, irpd_pkg::ZERO_MAX_RST,
                    irpd_pkg::ONE_MIN_RST, irpd_pkg::ONE_MAX_RST);
        run_traffic(300);
        settle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
